FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_AR(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/tmie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmie_pkg;

  localparam int unsigned ParamW = 17;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PtrW   = 32;

  typedef enum logic [ModeW-1:0] {
    OP_NOP  = 4'd0,
    OP_BRA  = 4'd1,
    OP_BZ   = 4'd2,
    OP_ADD  = 4'd3,
    OP_MOVE = 4'd4,
    OP_IN   = 4'd5,
    OP_OUT  = 4'd6,
    OP_DUMP = 4'd7,
    OP_INIT = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_RD   = 2'd1,
    FAULT_WR   = 2'd2
  } fault_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ParamW-1:0] param;
    logic [ByteW-1:0]         in_byte;
  } instr_t;

  typedef struct packed {
    logic signed [ParamW-1:0] pc_step;
    logic                     out_valid;
    logic [ByteW-1:0]         out_byte;
    fault_e                   fault;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tmie_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tmie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmie_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tmie_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned PtrLast = DEPTH - 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(PtrLast)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(PtrLast)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tmie_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                clearing_i,
  input  logic [tmie_pkg::ModeW-1:0]          mode_i,
  input  logic signed [tmie_pkg::ParamW-1:0]  param_i,
  input  logic [tmie_pkg::ByteW-1:0]          in_byte_i,
  output logic                                instr_valid_o,
  output tmie_pkg::instr_t                    instr_o,
  input  logic                                instr_pop_i
);

  localparam int unsigned InstrW = $bits(tmie_pkg::instr_t);

  tmie_pkg::instr_t  dec;
  logic              q_full, q_empty;
  logic [InstrW-1:0] q_rdata;

  // Unused mode codes run as nop.
  always_comb begin
    dec.param   = param_i;
    dec.in_byte = in_byte_i;
    if (mode_i <= tmie_pkg::OP_INIT) begin
      dec.op = tmie_pkg::op_e'(mode_i);
    end else begin
      dec.op = tmie_pkg::OP_NOP;
    end
  end

  assign full = q_full || clearing_i;

  tmie_fifo #(
    .WIDTH (InstrW),
    .DEPTH (2)
  ) u_instr_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .full_o  (q_full),
    .wdata_i (dec),
    .pop_i   (instr_pop_i),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign instr_valid_o = !q_empty;
  assign instr_o       = tmie_pkg::instr_t'(q_rdata);

endmodule

`default_nettype wire

FILE: hw/rtl/tmie_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tmie_back #(
  parameter int unsigned TAPE_DEPTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             instr_valid_i,
  input  tmie_pkg::instr_t instr_i,
  output logic             instr_pop_o,
  output logic             clearing_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output tmie_pkg::result_t res_o
);

  localparam int unsigned AW       = $clog2(TAPE_DEPTH);
  localparam int unsigned SizeW    = $clog2(TAPE_DEPTH + 1);
  localparam int unsigned TapeLast = TAPE_DEPTH - 1;
  localparam int unsigned PW       = tmie_pkg::ParamW;
  localparam int unsigned BW       = tmie_pkg::ByteW;
  localparam int unsigned DW       = tmie_pkg::PtrW;

  logic                  clear_q;
  logic [AW-1:0]         clr_addr_q;
  logic                  debug_q;
  logic [DW-1:0]         dp_q, dp_d;
  logic [SizeW-1:0]      size_q, size_d;
  logic                  ready_q, ready_d;

  logic                  s1_fire, s1_legal;
  logic [AW-1:0]         s1_addr;
  logic [DW-1:0]         param_u;

  logic                  s2_valid_q;
  tmie_pkg::instr_t      s2_instr_q;
  logic                  s2_legal_q;
  logic [AW-1:0]         s2_addr_q;
  logic                  s2_init_rep_q;
  logic                  s2_fire;
  logic                  fwd_hit_q;
  logic [BW-1:0]         fwd_data_q;

  logic [BW-1:0]         rd_data, cur_byte, wr_data;
  logic                  wr_en;
  tmie_pkg::result_t     res;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [BW-1:0]         ram_wdata;

  assign clearing_o  = clear_q;
  assign s2_fire     = s2_valid_q && !res_full_i;
  assign s1_fire     = instr_valid_i && !clear_q && (!s2_valid_q || s2_fire);
  assign instr_pop_o = s1_fire;

  assign s1_legal = (dp_q < DW'(size_q));
  assign s1_addr  = dp_q[AW-1:0];
  assign param_u  = {{(DW - PW){instr_i.param[PW-1]}}, instr_i.param};

  always_comb begin
    dp_d    = dp_q;
    size_d  = size_q;
    ready_d = ready_q;
    if (s1_fire) begin
      case (instr_i.op)
        tmie_pkg::OP_MOVE: begin
          dp_d = dp_q + param_u;
        end
        tmie_pkg::OP_INIT: begin
          if (!ready_q) begin
            ready_d = 1'b1;
            if (instr_i.param[PW-1]) begin
              size_d = '0;
            end else if (param_u > DW'(TAPE_DEPTH)) begin
              size_d = SizeW'(TAPE_DEPTH);
            end else begin
              size_d = SizeW'(param_u);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_byte = fwd_hit_q ? fwd_data_q : rd_data;

  always_comb begin
    res.pc_step   = PW'(1);
    res.out_valid = 1'b0;
    res.out_byte  = '0;
    res.fault     = tmie_pkg::FAULT_NONE;
    wr_en         = 1'b0;
    wr_data       = cur_byte;
    case (s2_instr_q.op)
      tmie_pkg::OP_BRA: begin
        res.pc_step = s2_instr_q.param;
      end
      tmie_pkg::OP_BZ: begin
        if (!s2_legal_q) begin
          res.fault = tmie_pkg::FAULT_RD;
        end else if (cur_byte == '0) begin
          res.pc_step = s2_instr_q.param;
        end
      end
      tmie_pkg::OP_ADD: begin
        if (!s2_legal_q) begin
          res.fault = tmie_pkg::FAULT_WR;
        end else begin
          wr_en   = 1'b1;
          wr_data = cur_byte + s2_instr_q.param[BW-1:0];
        end
      end
      tmie_pkg::OP_IN: begin
        if (!s2_legal_q) begin
          res.fault = tmie_pkg::FAULT_WR;
        end else begin
          wr_en   = 1'b1;
          wr_data = s2_instr_q.in_byte;
        end
      end
      tmie_pkg::OP_OUT: begin
        if (!s2_legal_q) begin
          res.fault = tmie_pkg::FAULT_RD;
        end else begin
          res.out_valid = 1'b1;
          res.out_byte  = cur_byte;
        end
      end
      tmie_pkg::OP_INIT: begin
        if (s2_init_rep_q) begin
          res.pc_step = debug_q ? PW'(2) : PW'(1);
        end
      end
      default: begin
      end
    endcase
    if (res.fault != tmie_pkg::FAULT_NONE) begin
      res.pc_step = '0;
    end
  end

  assign res_push_o = s2_fire;
  assign res_o      = res;

  assign ram_we    = clear_q || (s2_fire && wr_en);
  assign ram_waddr = clear_q ? clr_addr_q : s2_addr_q;
  assign ram_wdata = clear_q ? '0 : wr_data;

  tmie_ram #(
    .WIDTH (BW),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s1_fire),
    .raddr_i (s1_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      debug_q    <= 1'b0;
      dp_q       <= '0;
      size_q     <= '0;
      ready_q    <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (clear_q) begin
        if (clr_addr_q == AW'(TapeLast)) begin
          clear_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
      end
      if (cfg_we_i) begin
        debug_q <= cfg_data_i;
      end
      dp_q    <= dp_d;
      size_q  <= size_d;
      ready_q <= ready_d;
      if (s1_fire) begin
        s2_valid_q <= 1'b1;
        fwd_hit_q  <= s2_fire && wr_en && (s2_addr_q == s1_addr);
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_instr_q    <= instr_i;
      s2_legal_q    <= s1_legal;
      s2_addr_q     <= s1_addr;
      s2_init_rep_q <= (instr_i.op == tmie_pkg::OP_INIT) && ready_q;
      fwd_data_q    <= wr_data;
    end
  end

  `ASSERT_AR(a_no_issue_while_clearing, clk_i, rst_ni, clear_q |-> !instr_pop_o)
  `ASSERT_AR(a_stage2_empty_while_clearing, clk_i, rst_ni, clear_q |-> !s2_valid_q)
  `ASSERT_AR(a_ready_sticky, clk_i, rst_ni, ready_q |=> ready_q)
  `ASSERT_AR(a_size_in_range, clk_i, rst_ni, size_q <= SizeW'(TAPE_DEPTH))

endmodule

`default_nettype wire

FILE: hw/rtl/tape_machine_instruction_executor_core.sv
// Path: instruction queue, back-end stages one and two, result queue.
// Throughput: one instruction per cycle unless clearing or the result queue is full;
// the tape is read in one stage, written in the next, writes forwarding to reads.
// Reset: pointer, size and initialized flag clear at once; the tape is then swept
// to zero at one cell a cycle, with full held high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module tape_machine_instruction_executor_core #(
  parameter int unsigned TAPE_DEPTH = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic [tmie_pkg::ModeW-1:0]         mode_i,
  input  logic signed [tmie_pkg::ParamW-1:0] param_i,
  input  logic [tmie_pkg::ByteW-1:0]         in_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [tmie_pkg::ParamW-1:0] pc_step_o,
  output logic                               out_valid_o,
  output logic [tmie_pkg::ByteW-1:0]         out_byte_o,
  output logic [1:0]                         fault_o
);

  localparam int unsigned ResW = $bits(tmie_pkg::result_t);

  logic              clearing;
  logic              instr_valid, instr_pop;
  tmie_pkg::instr_t  instr;
  logic              res_full, res_push;
  tmie_pkg::result_t res_in, res_out;
  logic [ResW-1:0]   res_rdata;

  assign cfg_ready_o = 1'b1;

  tmie_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .clearing_i    (clearing),
    .mode_i        (mode_i),
    .param_i       (param_i),
    .in_byte_i     (in_byte_i),
    .instr_valid_o (instr_valid),
    .instr_o       (instr),
    .instr_pop_i   (instr_pop)
  );

  tmie_back #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .instr_valid_i (instr_valid),
    .instr_i       (instr),
    .instr_pop_o   (instr_pop),
    .clearing_o    (clearing),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  tmie_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_rdata)
  );

  assign res_out     = tmie_pkg::result_t'(res_rdata);
  assign pc_step_o   = res_out.pc_step;
  assign out_valid_o = res_out.out_valid;
  assign out_byte_o  = res_out.out_byte;
  assign fault_o     = res_out.fault;

endmodule

`default_nettype wire

FILE: bench/tb_tape_machine_instruction_executor_core.sv
`timescale 1ns / 1ps

module tb_tape_machine_instruction_executor_core;

  localparam int unsigned TAPE_DEPTH = 65536;
  localparam int unsigned LAT_HOLD   = 4;
  localparam int unsigned ModeW      = tmie_pkg::ModeW;
  localparam int unsigned ParamW     = tmie_pkg::ParamW;
  localparam int unsigned ByteW      = tmie_pkg::ByteW;
  localparam int unsigned PtrW       = tmie_pkg::PtrW;
  localparam logic [ModeW-1:0] MODE_TOP = '1;

  typedef struct {
    logic [ModeW-1:0]         mode;
    logic signed [ParamW-1:0] param;
    logic [ByteW-1:0]         in_byte;
  } tb_instr_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     cfg_data_i  = 1'b0;
  logic                     push        = 1'b0;
  logic                     full;
  logic [ModeW-1:0]         mode_i      = '0;
  logic signed [ParamW-1:0] param_i     = '0;
  logic [ByteW-1:0]         in_byte_i   = '0;
  logic                     empty;
  logic                     pop         = 1'b0;
  logic signed [ParamW-1:0] pc_step_o;
  logic                     out_valid_o;
  logic [ByteW-1:0]         out_byte_o;
  logic [1:0]               fault_o;

  tape_machine_instruction_executor_core #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .mode_i     (mode_i),
    .param_i    (param_i),
    .in_byte_i  (in_byte_i),
    .empty      (empty),
    .pop        (pop),
    .pc_step_o  (pc_step_o),
    .out_valid_o(out_valid_o),
    .out_byte_o (out_byte_o),
    .fault_o    (fault_o)
  );

  // machine state as the block should hold it
  bit   [ByteW-1:0] tape_m [TAPE_DEPTH];
  logic [PtrW-1:0]  ptr_m     = '0;
  logic [16:0]      size_m    = '0;
  bit               ready_m   = 1'b0;
  bit               dbg_skip_m = 1'b0;

  tb_instr_t             instr_q[$];
  tmie_pkg::result_t     exec_results_q[$];
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned pop_hold = 0;
  int          shadow_ptr = 0;
  int          size_sh = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tmie_pkg::result_t run_instr(tb_instr_t ins);
    tmie_pkg::result_t res;
    bit                cell_ok;
    int                p;
    res.pc_step   = ParamW'(1);
    res.out_valid = 1'b0;
    res.out_byte  = '0;
    res.fault     = tmie_pkg::FAULT_NONE;
    p = ins.param;
    cell_ok = ptr_m < {15'd0, size_m};
    case (ins.mode)
      tmie_pkg::OP_BRA: res.pc_step = ins.param;
      tmie_pkg::OP_BZ: begin
        if (!cell_ok) res.fault = tmie_pkg::FAULT_RD;
        else if (tape_m[ptr_m[15:0]] == 0) res.pc_step = ins.param;
      end
      tmie_pkg::OP_ADD: begin
        if (!cell_ok) res.fault = tmie_pkg::FAULT_WR;
        else tape_m[ptr_m[15:0]] = tape_m[ptr_m[15:0]] + ins.param[ByteW-1:0];
      end
      tmie_pkg::OP_MOVE: ptr_m = ptr_m + {{(PtrW-ParamW){ins.param[ParamW-1]}}, ins.param};
      tmie_pkg::OP_IN: begin
        if (!cell_ok) res.fault = tmie_pkg::FAULT_WR;
        else tape_m[ptr_m[15:0]] = ins.in_byte;
      end
      tmie_pkg::OP_OUT: begin
        if (!cell_ok) begin
          res.fault = tmie_pkg::FAULT_RD;
        end else begin
          res.out_valid = 1'b1;
          res.out_byte  = tape_m[ptr_m[15:0]];
        end
      end
      tmie_pkg::OP_INIT: begin
        if (!ready_m) begin
          ready_m = 1'b1;
          if (p < 0) size_m = '0;
          else if (p > int'(TAPE_DEPTH)) size_m = 17'(TAPE_DEPTH);
          else size_m = 17'(p);
        end else begin
          res.pc_step = dbg_skip_m ? ParamW'(2) : ParamW'(1);
        end
      end
      default: ;
    endcase
    if (res.fault != tmie_pkg::FAULT_NONE) res.pc_step = '0;
    return res;
  endfunction

  // driver: one beat per free slot, random gaps between beats
  always @(posedge clk_i) begin : drv
    tb_instr_t ins;
    bit        go;
    go = push;
    if (push && !full) begin
      ins.mode    = mode_i;
      ins.param   = param_i;
      ins.in_byte = in_byte_i;
      exec_results_q.push_back(run_instr(ins));
      go = 1'b0;
    end
    if (!go && rst_ni) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (instr_q.size() > 0) begin
        ins = instr_q.pop_front();
        mode_i    <= ins.mode;
        param_i   <= ins.param;
        in_byte_i <= ins.in_byte;
        go = 1'b1;
        send_gap <= pick_gap(no_idle);
      end
    end
    push <= go;
  end

  // monitor: compare each beat with the oldest prediction
  always @(posedge clk_i) begin : mon
    tmie_pkg::result_t want;
    int unsigned       hold;
    hold = pop_hold;
    if (rst_ni && pop && !empty) begin
      if (exec_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: step %0d valid %0b byte %02h fault %0d",
                   pc_step_o, out_valid_o, out_byte_o, fault_o);
      end else begin
        want = exec_results_q.pop_front();
        if (pc_step_o !== want.pc_step || out_valid_o !== want.out_valid ||
            out_byte_o !== want.out_byte || fault_o !== want.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp step %0d valid %0b byte %02h fault %0d, ",
                      "got step %0d valid %0b byte %02h fault %0d"},
                     want.pc_step, want.out_valid, want.out_byte, want.fault,
                     pc_step_o, out_valid_o, out_byte_o, fault_o);
        end
      end
      hold = pick_gap(no_idle);
    end
    if (hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= hold - 1;
    end else begin
      pop      <= rst_ni;
      pop_hold <= 0;
    end
  end

  task automatic add_instr(logic [ModeW-1:0] mode, logic signed [ParamW-1:0] param,
                           logic [ByteW-1:0] in_byte);
    tb_instr_t ins;
    ins.mode    = mode;
    ins.param   = param;
    ins.in_byte = in_byte;
    instr_q.push_back(ins);
    if (mode == tmie_pkg::OP_MOVE) shadow_ptr += param;
  endtask

  task automatic gen_random(int unsigned n);
    int unsigned              r;
    int                       target;
    logic signed [ParamW-1:0] p;
    logic [ByteW-1:0]         b;
    repeat (n) begin
      r = $urandom_range(0, 99);
      p = ParamW'($urandom);
      b = ByteW'($urandom);
      if (r < 24) begin
        add_instr(tmie_pkg::OP_ADD, p, b);
      end else if (r < 38) begin
        add_instr(tmie_pkg::OP_IN, p, b);
      end else if (r < 52) begin
        add_instr(tmie_pkg::OP_OUT, p, b);
      end else if (r < 64) begin
        add_instr(tmie_pkg::OP_BZ, p, b);
      end else if (r < 78) begin
        if ($urandom_range(0, 9) == 0) target = $urandom_range(0, 1) ? -1 : size_sh;
        else target = $urandom_range(0, size_sh - 1);
        add_instr(tmie_pkg::OP_MOVE, ParamW'(target - shadow_ptr), b);
      end else if (r < 84) begin
        add_instr(tmie_pkg::OP_BRA, p, b);
      end else if (r < 88) begin
        add_instr($urandom_range(0, 1) ? tmie_pkg::OP_DUMP : tmie_pkg::OP_NOP, p, b);
      end else if (r < 91) begin
        add_instr(tmie_pkg::OP_INIT, p, b);
      end else if (r < 94) begin
        add_instr(ModeW'($urandom_range(int'(MODE_TOP), int'(tmie_pkg::OP_INIT) + 1)),
                  p, b);
      end else begin
        // jump far off the tape, touch it, come back
        p = ParamW'($urandom_range(1, 65535));
        if ($urandom_range(0, 1)) p = -p;
        add_instr(tmie_pkg::OP_MOVE, p, b);
        add_instr($urandom_range(0, 1) ? tmie_pkg::OP_OUT : tmie_pkg::OP_ADD,
                  ParamW'($urandom), b);
        add_instr(tmie_pkg::OP_MOVE, -p, b);
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (instr_q.size() != 0 || push || exec_results_q.size() != 0);
    repeat (LAT_HOLD) @(negedge clk_i);
  endtask

  task automatic write_debug(bit v);
    @(posedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    dbg_skip_m = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_debug(1'b0);
    size_sh = $urandom_range(16, 40);
    @(negedge clk_i);
    add_instr(tmie_pkg::OP_OUT, ParamW'(0), 8'h00);
    add_instr(tmie_pkg::OP_BZ, ParamW'(5), 8'h00);
    add_instr(tmie_pkg::OP_ADD, ParamW'(1), 8'h00);
    add_instr(tmie_pkg::OP_IN, ParamW'(0), 8'hAA);
    add_instr(tmie_pkg::OP_NOP, ParamW'(65535), 8'hFF);
    add_instr(tmie_pkg::OP_DUMP, ParamW'(-65536), 8'h00);
    add_instr(tmie_pkg::OP_BRA, ParamW'(-65536), 8'h00);
    add_instr(tmie_pkg::OP_BRA, ParamW'(65535), 8'h00);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(-65536), 8'h00);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(65535), 8'h00);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(1), 8'h00);
    add_instr(MODE_TOP, ParamW'(0), 8'h00);
    add_instr(tmie_pkg::OP_INIT, ParamW'(size_sh), 8'h00);
    add_instr(tmie_pkg::OP_INIT, ParamW'(-65536), 8'h00);
    add_instr(tmie_pkg::OP_IN, ParamW'(0), 8'hFF);
    add_instr(tmie_pkg::OP_OUT, ParamW'(0), 8'h00);
    add_instr(tmie_pkg::OP_ADD, ParamW'(1), 8'h00);
    add_instr(tmie_pkg::OP_BZ, ParamW'(-65536), 8'h00);
    add_instr(tmie_pkg::OP_ADD, ParamW'(65535), 8'h00);
    add_instr(tmie_pkg::OP_BZ, ParamW'(100), 8'h00);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(-1), 8'h00);
    add_instr(tmie_pkg::OP_OUT, ParamW'(0), 8'h00);
    add_instr(tmie_pkg::OP_IN, ParamW'(0), 8'h55);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(size_sh + 1), 8'h00);
    add_instr(tmie_pkg::OP_ADD, ParamW'(7), 8'h00);
    add_instr(tmie_pkg::OP_MOVE, ParamW'(-size_sh), 8'h00);
    drain();

    write_debug(1'b1);
    @(negedge clk_i);
    add_instr(tmie_pkg::OP_INIT, ParamW'(65535), 8'h00);
    add_instr(tmie_pkg::OP_INIT, ParamW'(-1), 8'h00);
    add_instr(tmie_pkg::OP_DUMP, ParamW'(0), 8'h00);
    gen_random(130);
    drain();

    write_debug(1'b0);
    @(negedge clk_i);
    no_idle = 1'b1;
    gen_random(120);
    drain();

    write_debug(1'b1);
    @(negedge clk_i);
    no_idle = 1'b0;
    gen_random(130);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && exec_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
